### rtl/core/nast_pkg.sv
package nast_pkg;

	localparam int unsigned SEC_PER_DAY   = 86400;
	localparam int unsigned SEC_PER_HOUR  = 3600;
	localparam int unsigned SEC_PER_MIN   = 60;
	localparam int unsigned FREQ_W        = 8;
	localparam int unsigned TOD_W         = 17;
	localparam int unsigned NEXT_W        = 18;
	localparam int unsigned QUOT_W        = 9;
	localparam int unsigned MONTHS        = 12;
	localparam int unsigned FEB           = 2;
	localparam int unsigned FEB_LEAP_DAYS = 29;
	localparam int unsigned FEB_DAYS      = 28;
	localparam int unsigned ODD_MONTH_DAYS = 31;
	localparam int unsigned YEAR_WRAP     = 100;

	localparam logic [4:0] MONTH_DAYS [MONTHS] = '{
		5'd31, 5'd28, 5'd31, 5'd30, 5'd31, 5'd30,
		5'd31, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31
	};

	typedef enum logic [1:0] {
		STAT_VALID = 2'd0,
		STAT_ZERO  = 2'd1,
		STAT_NODIV = 2'd2
	} stat_t;

	typedef struct packed {
		logic [6:0] year;
		logic [3:0] month;
		logic [4:0] day;
		logic [4:0] hours;
		logic [5:0] minutes;
		logic [5:0] seconds;
	} stamp_t;

	typedef struct packed {
		stamp_t              cur;
		logic [NEXT_W-1:0]   nxt;
		stat_t               stat;
	} mid_t;

	typedef struct packed {
		stamp_t nxt;
		stat_t  stat;
	} res_t;

endpackage

### rtl/core/next_aligned_sample_time_unit.sv
// next_aligned_sample_time_unit: next collection instant on a per-day grid
// throughput: one beat per cycle while full is low, the remainder pipeline takes one quotient bit per stage
// reset: pipelines and queues flushed, collection frequency back to 1
module next_aligned_sample_time_unit #(
	parameter int unsigned MID_DEPTH = 4,
	parameter int unsigned OUT_DEPTH = 2
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push,
	output logic       full,
	input  logic [6:0] cur_year,
	input  logic [3:0] cur_month,
	input  logic [4:0] cur_day,
	input  logic [4:0] cur_hours,
	input  logic [5:0] cur_minutes,
	input  logic [5:0] cur_seconds,
	input  logic       cfg_wr_en,
	input  logic [7:0] cfg_wr_data,
	output logic       empty,
	input  logic       pop,
	output logic [6:0] next_year,
	output logic [3:0] next_month,
	output logic [4:0] next_day,
	output logic [4:0] next_hours,
	output logic [5:0] next_minutes,
	output logic [5:0] next_seconds_out,
	output logic [1:0] freq_status
);
	import nast_pkg::*;

	stamp_t item;
	logic   mid_push, mid_full, mid_pop, mid_empty;
	mid_t   mid_wdata, mid_rdata;
	logic   res_push, res_full;
	res_t   res_wdata, res_rdata;

	assign item = '{year: cur_year, month: cur_month, day: cur_day,
		hours: cur_hours, minutes: cur_minutes, seconds: cur_seconds};

	nast_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.push        (push),
		.full        (full),
		.item        (item),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.mid_push    (mid_push),
		.mid_data    (mid_wdata),
		.mid_full    (mid_full)
	);

	nast_fifo #(
		.DEPTH (MID_DEPTH),
		.WIDTH ($bits(mid_t))
	) u_mid_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (mid_push),
		.wdata  (mid_wdata),
		.full   (mid_full),
		.pop    (mid_pop),
		.rdata  (mid_rdata),
		.empty  (mid_empty)
	);

	nast_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.mid_empty (mid_empty),
		.mid_pop   (mid_pop),
		.mid_data  (mid_rdata),
		.res_push  (res_push),
		.res_data  (res_wdata),
		.res_full  (res_full)
	);

	nast_fifo #(
		.DEPTH (OUT_DEPTH),
		.WIDTH ($bits(res_t))
	) u_out_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (res_push),
		.wdata  (res_wdata),
		.full   (res_full),
		.pop    (pop),
		.rdata  (res_rdata),
		.empty  (empty)
	);

	assign next_year        = res_rdata.nxt.year;
	assign next_month       = res_rdata.nxt.month;
	assign next_day         = res_rdata.nxt.day;
	assign next_hours       = res_rdata.nxt.hours;
	assign next_minutes     = res_rdata.nxt.minutes;
	assign next_seconds_out = res_rdata.nxt.seconds;
	assign freq_status      = res_rdata.stat;

	a_tod_range: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && freq_status != STAT_ZERO) |->
		(next_hours <= 5'd23 && next_minutes <= 6'd59 && next_seconds_out <= 6'd59))
		else $error("result time of day out of range");

	a_full_cause: assert property (@(posedge clk) disable iff (!arst_n)
		full |-> mid_full)
		else $error("input stalled while mid queue has room");

	a_out_source: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(empty) |-> $past(res_push))
		else $error("result appeared without a beat from the back end");

endmodule

### rtl/core/nast_fifo.sv
module nast_fifo #(
	parameter int unsigned DEPTH = 4,
	parameter int unsigned WIDTH = 8
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] wdata,
	output logic             full,
	input  logic             pop,
	output logic [WIDTH-1:0] rdata,
	output logic             empty
);
	localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [AW-1:0]    wr_ptr_q;
	logic [AW-1:0]    rd_ptr_q;
	logic [CW-1:0]    cnt_q;
	logic             do_push;
	logic             do_pop;

	assign full    = (cnt_q == CW'(DEPTH));
	assign empty   = (cnt_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign rdata   = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + AW'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + AW'(1);
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + CW'(1);
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - CW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= wdata;
		end
	end

endmodule

### rtl/core/nast_front.sv
module nast_front (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          push,
	output logic                          full,
	input  nast_pkg::stamp_t              item,
	input  logic                          cfg_wr_en,
	input  logic [nast_pkg::FREQ_W-1:0]   cfg_wr_data,
	output logic                          mid_push,
	output nast_pkg::mid_t                mid_data,
	input  logic                          mid_full
);
	import nast_pkg::*;

	localparam int unsigned FREQ_N = 2 ** FREQ_W;
	localparam int unsigned DIV_W  = TOD_W + QUOT_W;

	typedef struct packed {
		stamp_t             cur;
		logic [TOD_W-1:0]   now;
		logic [TOD_W-1:0]   rem;
		logic [TOD_W-1:0]   ival;
		stat_t              stat;
	} front_t;

	logic [TOD_W-1:0] ival_tab [FREQ_N];
	stat_t            stat_tab [FREQ_N];
	logic [TOD_W-1:0] ival_q;
	stat_t            stat_q;

	logic             en;
	logic [TOD_W-1:0] now_w;
	front_t           in_s1;
	logic             v_s1;
	front_t           div_in  [QUOT_W];
	front_t           div_out [QUOT_W];
	front_t           div_s   [QUOT_W];
	logic [QUOT_W-1:0] div_v_s;
	mid_t             nxt_s11;
	logic             v_s11;

	// interval and divisor check per frequency, folded at elaboration
	for (genvar g = 0; g < FREQ_N; g++) begin : g_tab
		localparam int unsigned IVAL = (g == 0) ? 0 : SEC_PER_DAY / g;
		localparam int unsigned IREM = (g == 0) ? 0 : SEC_PER_DAY % g;
		assign ival_tab[g] = TOD_W'(IVAL);
		assign stat_tab[g] = (g == 0) ? STAT_ZERO : ((IREM == 0) ? STAT_VALID : STAT_NODIV);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ival_q <= TOD_W'(SEC_PER_DAY);
			stat_q <= STAT_VALID;
		end else if (cfg_wr_en) begin
			ival_q <= ival_tab[cfg_wr_data];
			stat_q <= stat_tab[cfg_wr_data];
		end
	end

	assign now_w = TOD_W'(item.hours) * TOD_W'(SEC_PER_HOUR)
		+ TOD_W'(item.minutes) * TOD_W'(SEC_PER_MIN)
		+ TOD_W'(item.seconds);

	// restoring remainder, one quotient bit per stage
	for (genvar k = 0; k < QUOT_W; k++) begin : g_div
		localparam int unsigned SH = QUOT_W - 1 - k;
		logic [DIV_W-1:0] r_w;
		logic [DIV_W-1:0] d_w;
		logic             ge;

		if (k == 0) begin : g_first
			assign div_in[k] = in_s1;
		end else begin : g_next
			assign div_in[k] = div_s[k-1];
		end

		assign r_w = DIV_W'(div_in[k].rem);
		assign d_w = DIV_W'(div_in[k].ival) << SH;
		assign ge  = (r_w >= d_w);
		assign div_out[k] = '{
			cur:  div_in[k].cur,
			now:  div_in[k].now,
			rem:  ge ? TOD_W'(r_w - d_w) : div_in[k].rem,
			ival: div_in[k].ival,
			stat: div_in[k].stat
		};
	end

	assign en       = !(v_s11 && mid_full);
	assign full     = !en;
	assign mid_push = v_s11 && !mid_full;
	assign mid_data = nxt_s11;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1    <= 1'b0;
			div_v_s <= '0;
			v_s11   <= 1'b0;
		end else if (en) begin
			v_s1    <= push;
			div_v_s <= {div_v_s[QUOT_W-2:0], v_s1};
			v_s11   <= div_v_s[QUOT_W-1];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			in_s1 <= '{cur: item, now: now_w, rem: now_w, ival: ival_q, stat: stat_q};
			for (int k = 0; k < QUOT_W; k++) begin
				div_s[k] <= div_out[k];
			end
			// boundary after now is now minus remainder plus one interval
			nxt_s11 <= '{
				cur:  div_s[QUOT_W-1].cur,
				nxt:  NEXT_W'(div_s[QUOT_W-1].now) - NEXT_W'(div_s[QUOT_W-1].rem)
					+ NEXT_W'(div_s[QUOT_W-1].ival),
				stat: div_s[QUOT_W-1].stat
			};
		end
	end

endmodule

### rtl/core/nast_back.sv
module nast_back (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            mid_empty,
	output logic            mid_pop,
	input  nast_pkg::mid_t  mid_data,
	output logic            res_push,
	output nast_pkg::res_t  res_data,
	input  logic            res_full
);
	import nast_pkg::*;

	localparam int unsigned HOUR_W = 5;
	localparam int unsigned MIN_W  = 6;

	typedef struct packed {
		logic [6:0] year;
		logic [3:0] month;
		logic [5:0] day;
	} cal_t;

	typedef struct packed {
		cal_t               cal;
		logic [4:0]         cur_hours;
		logic [5:0]         cur_minutes;
		logic [5:0]         cur_seconds;
		logic [TOD_W-1:0]   tod;
		logic [4:0]         hours;
		logic [5:0]         minutes;
		logic [5:0]         seconds;
		stat_t              stat;
	} back_t;

	function automatic logic [4:0] month_len(input logic [6:0] year, input logic [3:0] month);
		logic [4:0] len;
		if (month == 4'(FEB)) begin
			len = (year[1:0] == 2'd0) ? 5'(FEB_LEAP_DAYS) : 5'(FEB_DAYS);
		end else if (month inside {[1:MONTHS]}) begin
			len = MONTH_DAYS[month - 4'd1];
		end else begin
			len = 5'(ODD_MONTH_DAYS);
		end
		return len;
	endfunction

	function automatic cal_t cal_step(input cal_t c);
		cal_t       r;
		logic [5:0] len;
		logic [7:0] y1;
		r   = c;
		len = {1'b0, month_len(c.year, c.month)};
		y1  = {1'b0, c.year} + 8'd1;
		if (c.day > len) begin
			r.day = c.day - len;
			if (c.month >= 4'(MONTHS)) begin
				r.month = 4'd1;
				r.year  = (y1 >= 8'(YEAR_WRAP)) ? 7'(y1 - 8'(YEAR_WRAP)) : y1[6:0];
			end else begin
				r.month = c.month + 4'd1;
			end
		end
		return r;
	endfunction

	logic   en;
	back_t  b1_d, b2_d, b3_d, b4_d;
	res_t   r5_d;
	back_t  b_s1, b_s2, b_s3, b_s4;
	res_t   res_s5;
	logic   v_s1, v_s2, v_s3, v_s4, v_s5;

	// whole days off the boundary
	always_comb begin
		b1_d.cal         = '{year: mid_data.cur.year, month: mid_data.cur.month,
			day: {1'b0, mid_data.cur.day}};
		b1_d.cur_hours   = mid_data.cur.hours;
		b1_d.cur_minutes = mid_data.cur.minutes;
		b1_d.cur_seconds = mid_data.cur.seconds;
		b1_d.tod         = mid_data.nxt[TOD_W-1:0];
		b1_d.hours       = '0;
		b1_d.minutes     = '0;
		b1_d.seconds     = '0;
		b1_d.stat        = mid_data.stat;
		if (mid_data.stat != STAT_ZERO) begin
			if (mid_data.nxt >= NEXT_W'(2 * SEC_PER_DAY)) begin
				b1_d.tod     = TOD_W'(mid_data.nxt - NEXT_W'(2 * SEC_PER_DAY));
				b1_d.cal.day = b1_d.cal.day + 6'd2;
			end else if (mid_data.nxt >= NEXT_W'(SEC_PER_DAY)) begin
				b1_d.tod     = TOD_W'(mid_data.nxt - NEXT_W'(SEC_PER_DAY));
				b1_d.cal.day = b1_d.cal.day + 6'd1;
			end
		end
	end

	// hours, one bit per step
	always_comb begin
		logic [TOD_W-1:0]  r;
		logic [HOUR_W-1:0] h;
		logic              ge;
		r = b_s1.tod;
		h = '0;
		for (int b = HOUR_W - 1; b >= 0; b--) begin
			ge = (r >= TOD_W'(SEC_PER_HOUR << b));
			if (ge) begin
				r = r - TOD_W'(SEC_PER_HOUR << b);
			end
			h = {h[HOUR_W-2:0], ge};
		end
		b2_d       = b_s1;
		b2_d.tod   = r;
		b2_d.hours = h;
		b2_d.cal   = (b_s1.stat == STAT_ZERO) ? b_s1.cal : cal_step(b_s1.cal);
	end

	// minutes and seconds
	always_comb begin
		logic [TOD_W-1:0] r;
		logic [MIN_W-1:0] m;
		logic             ge;
		r = b_s2.tod;
		m = '0;
		for (int b = MIN_W - 1; b >= 0; b--) begin
			ge = (r >= TOD_W'(SEC_PER_MIN << b));
			if (ge) begin
				r = r - TOD_W'(SEC_PER_MIN << b);
			end
			m = {m[MIN_W-2:0], ge};
		end
		b3_d         = b_s2;
		b3_d.minutes = m;
		b3_d.seconds = r[5:0];
		b3_d.cal     = (b_s2.stat == STAT_ZERO) ? b_s2.cal : cal_step(b_s2.cal);
	end

	always_comb begin
		b4_d     = b_s3;
		b4_d.cal = (b_s3.stat == STAT_ZERO) ? b_s3.cal : cal_step(b_s3.cal);
	end

	always_comb begin
		cal_t c;
		c = (b_s4.stat == STAT_ZERO) ? b_s4.cal : cal_step(b_s4.cal);
		r5_d.stat      = b_s4.stat;
		r5_d.nxt.year  = c.year;
		r5_d.nxt.month = c.month;
		r5_d.nxt.day   = c.day[4:0];
		if (b_s4.stat == STAT_ZERO) begin
			r5_d.nxt.hours   = b_s4.cur_hours;
			r5_d.nxt.minutes = b_s4.cur_minutes;
			r5_d.nxt.seconds = b_s4.cur_seconds;
		end else begin
			r5_d.nxt.hours   = b_s4.hours;
			r5_d.nxt.minutes = b_s4.minutes;
			r5_d.nxt.seconds = b_s4.seconds;
		end
	end

	assign en       = !(v_s5 && res_full);
	assign mid_pop  = en && !mid_empty;
	assign res_push = v_s5 && !res_full;
	assign res_data = res_s5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else if (en) begin
			v_s1 <= !mid_empty;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			b_s1   <= b1_d;
			b_s2   <= b2_d;
			b_s3   <= b3_d;
			b_s4   <= b4_d;
			res_s5 <= r5_d;
		end
	end

endmodule
